FILE: design/twba_pkg.sv
// Package for the time-weighted brightness average block.
// Field widths, limits, APB register map, status and request codes, state encoding, control and status structs.
// No dependencies.
package twba_pkg;

    // Field widths
    localparam int TS_W           = 48;
    localparam int LVL_W          = 14;
    localparam int ST_W           = 2;
    localparam int SUM_W          = 64;
    localparam int TIME_WIDTH_DEF = 48;

    // Highest accepted brightness level
    localparam int MAX_LEVEL = 10000;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_STATS_ENABLE = 1'b0;

    // Request codes
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_DISABLED = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Control from the sequencer to the accumulator
    typedef struct packed {
        logic start;
        logic clear;
        logic level_we;
    } t_acc_ctrl;

    // Status from the accumulator to the sequencer
    typedef struct packed {
        logic done;
        logic ts_nz;
        logic ws_nz;
    } t_acc_stat;

endpackage

FILE: design/twba_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
// Depends on twba_pkg.
interface twba_req_if;
    import twba_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [TS_W-1:0]  timestamp_ms;
    logic [LVL_W-1:0] brightness;

    modport source (output valid, req_type, timestamp_ms, brightness, input ready);
    modport sink   (input valid, req_type, timestamp_ms, brightness, output ready);
endinterface

FILE: design/twba_rsp_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on twba_pkg.
interface twba_rsp_if;
    import twba_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [LVL_W-1:0] average_brightness;

    modport source (output valid, status, average_brightness, input ready);
    modport sink   (input valid, status, average_brightness, output ready);
endinterface

FILE: design/time_weighted_brightness_average.sv
// Time-weighted brightness average, top level: sequencer, APB register, result register.
// An accepted update runs the serial accumulator; a read runs it and then the divider,
// unless a sum is zero; a rejected update goes straight to the result register.
// One item at a time: the next is accepted only once the result is registered.
// Reset (i_rst_n, synchronous, active low) clears enable, previous time, level and both sums.
// Depends on twba_pkg, twba_req_if, twba_rsp_if, twba_acc, twba_div.
module time_weighted_brightness_average #(
    parameter int TIME_WIDTH = twba_pkg::TIME_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    twba_req_if.sink                     i_req,
    twba_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twba_pkg::PADDR_W-1:0] paddr,
    input  logic [twba_pkg::PDATA_W-1:0] pwdata,
    output logic [twba_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import twba_pkg::*;

    t_state           r_state;
    logic             r_stats_enable;
    logic             r_is_read;
    logic [LVL_W-1:0] r_level_new;
    logic [ST_W-1:0]  r_status;
    logic [LVL_W-1:0] r_avg;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    logic [LVL_W-1:0] r_out_avg;

    t_acc_ctrl        w_acc_ctrl;
    t_acc_stat        w_acc_stat;
    logic [SUM_W-1:0] w_time_sum;
    logic [SUM_W-1:0] w_weighted_sum;
    logic             w_div_start;
    logic             w_div_done;
    logic [SUM_W-1:0] w_quot;
    logic [LVL_W-1:0] w_avg_sat;
    logic             w_accept;
    logic             w_out_free;
    logic             w_cfg_wr;
    logic             w_in_range;
    logic             w_both_nz;

    // APB: single register, always ready
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_STATS_ENABLE);
    assign prdata   = (paddr[PADDR_W-1] == REG_STATS_ENABLE)
                    ? {{(PDATA_W - 1){1'b0}}, r_stats_enable} : '0;

    // Handshake and decode
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid & i_req.ready;
    assign w_out_free  = ~r_out_valid | o_rsp.ready;
    assign w_in_range  = ({2'b00, i_req.brightness} <= (LVL_W + 2)'(MAX_LEVEL));
    assign w_both_nz   = w_acc_stat.ts_nz & w_acc_stat.ws_nz;

    // Accumulator and divider control
    always_comb begin
        w_acc_ctrl.start    = w_accept & ((i_req.req_type == REQ_READ)
                            | (r_stats_enable & w_in_range));
        w_acc_ctrl.level_we = (r_state == S_ACC) & w_acc_stat.done & ~r_is_read;
        w_acc_ctrl.clear    = (r_state == S_ACC) & w_acc_stat.done & r_is_read;
        w_div_start         = w_acc_ctrl.clear & w_both_nz;
    end

    // Quotient saturates at the top level
    assign w_avg_sat = (w_quot > SUM_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : w_quot[LVL_W-1:0];

    twba_acc #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_acc_ctrl),
        .i_now          (TIME_WIDTH'(i_req.timestamp_ms)),
        .i_level        (r_level_new),
        .o_stat         (w_acc_stat),
        .o_time_sum     (w_time_sum),
        .o_weighted_sum (w_weighted_sum)
    );

    twba_div #(
        .W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_weighted_sum),
        .i_divisor  (w_time_sum),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_stats_enable <= 1'b0;
            r_is_read      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_stats_enable <= pwdata[0];
            end
            // in S_DONE the result register is reloaded below
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_is_read   <= (i_req.req_type == REQ_READ);
                        r_level_new <= i_req.brightness;
                        r_avg       <= '0;
                        if (i_req.req_type == REQ_READ) begin
                            r_status <= ST_OK;
                            r_state  <= S_ACC;
                        end else if (!r_stats_enable) begin
                            r_status <= ST_DISABLED;
                            r_state  <= S_DONE;
                        end else if (!w_in_range) begin
                            r_status <= ST_RANGE;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (w_acc_stat.done) begin
                        r_state <= (r_is_read && w_both_nz) ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_avg   <= w_avg_sat;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_avg    <= r_avg;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.status             = r_out_status;
    assign o_rsp.average_brightness = r_out_avg;

    // Divider never runs while the accumulator is still shifting
    a_div_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_state == S_ACC) && w_acc_stat.done && r_is_read)
        else $error("divider started outside end of read accumulation");

    // Average never exceeds the level limit
    a_avg_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_avg <= LVL_W'(MAX_LEVEL)))
        else $error("average above limit");

    // Non-OK status carries a zero average
    a_err_zero_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_avg == '0))
        else $error("rejected item with nonzero average");

    // A read clears both sums, which are zero in the cycle after the clear
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_ctrl.clear |=> (w_time_sum == '0) && (w_weighted_sum == '0))
        else $error("sums not cleared by read");

endmodule

FILE: design/twba_acc.sv
// Bit-serial interval accumulator: elapsed time, level x time product, both sums.
// One bit per cycle, LSB first, across all SUM_W bits of the sums. Depends on twba_pkg.
module twba_acc #(
    parameter int TIME_WIDTH = twba_pkg::TIME_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  twba_pkg::t_acc_ctrl          i_ctrl,
    input  logic [TIME_WIDTH-1:0]        i_now,
    input  logic [twba_pkg::LVL_W-1:0]   i_level,
    output twba_pkg::t_acc_stat          o_stat,
    output logic [twba_pkg::SUM_W-1:0]   o_time_sum,
    output logic [twba_pkg::SUM_W-1:0]   o_weighted_sum
);
    import twba_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_prev;
    logic [LVL_W-1:0]      r_level;
    logic [SUM_W-1:0]      r_ts;
    logic [SUM_W-1:0]      r_ws;
    logic                  r_borrow;
    logic                  r_cy_t;
    logic                  r_cy_w;
    logic [LVL_W-1:0]      r_pp;
    logic                  r_ts_nz;
    logic                  r_ws_nz;

    logic                  w_in_tw;
    logic                  w_lit;
    logic                  w_nb;
    logic                  w_pb;
    logic                  w_dbit;
    logic                  n_borrow;
    logic                  w_dt;
    logic                  w_tbit;
    logic                  n_cy_t;
    logic [LVL_W:0]        w_pp;
    logic                  w_pbit;
    logic                  w_wbit;
    logic                  n_cy_w;

    // Serial datapath: dt = now - prev, time_sum += dt, weighted_sum += level * dt
    always_comb begin
        w_in_tw  = ({1'b0, r_cnt} < (CNT_W + 1)'(TIME_WIDTH));
        w_lit    = (r_level != '0);
        w_nb     = r_now[0];
        w_pb     = r_prev[0];
        w_dbit   = w_nb ^ w_pb ^ r_borrow;
        n_borrow = (~w_nb & w_pb) | (~(w_nb ^ w_pb) & r_borrow);
        // dark interval or bits past the time width add nothing
        w_dt     = w_in_tw & w_lit & w_dbit;
        w_tbit   = r_ts[0] ^ w_dt ^ r_cy_t;
        n_cy_t   = (r_ts[0] & w_dt) | (r_ts[0] & r_cy_t) | (w_dt & r_cy_t);
        // serial-parallel multiply: dt bit stream times parallel level
        w_pp     = {1'b0, r_pp} + (w_dt ? {1'b0, r_level} : '0);
        w_pbit   = w_pp[0];
        w_wbit   = r_ws[0] ^ w_pbit ^ r_cy_w;
        n_cy_w   = (r_ws[0] & w_pbit) | (r_ws[0] & r_cy_w) | (w_pbit & r_cy_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
            r_prev   <= '0;
            r_level  <= '0;
            r_ts     <= '0;
            r_ws     <= '0;
            r_borrow <= 1'b0;
            r_cy_t   <= 1'b0;
            r_cy_w   <= 1'b0;
            r_pp     <= '0;
            r_ts_nz  <= 1'b0;
            r_ws_nz  <= 1'b0;
        end else begin
            // done pulses for one cycle after the last bit
            r_done <= ~i_ctrl.start & r_busy & (r_cnt == CNT_W'(SUM_W - 1));
            if (i_ctrl.start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_now    <= i_now;
                r_borrow <= 1'b0;
                r_cy_t   <= 1'b0;
                r_cy_w   <= 1'b0;
                r_pp     <= '0;
                r_ts_nz  <= 1'b0;
                r_ws_nz  <= 1'b0;
            end else if (r_busy) begin
                // rotate sums, new bits enter at the top
                r_ts    <= {w_tbit, r_ts[SUM_W-1:1]};
                r_ws    <= {w_wbit, r_ws[SUM_W-1:1]};
                r_cy_t  <= n_cy_t;
                r_cy_w  <= n_cy_w;
                r_pp    <= w_pp[LVL_W:1];
                r_ts_nz <= r_ts_nz | w_tbit;
                r_ws_nz <= r_ws_nz | w_wbit;
                // now shifts into prev, which ends up holding now
                if (w_in_tw) begin
                    r_now    <= r_now >> 1;
                    r_prev   <= {w_nb, r_prev[TIME_WIDTH-1:1]};
                    r_borrow <= n_borrow;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_ctrl.clear) begin
                r_ts <= '0;
                r_ws <= '0;
            end
            if (i_ctrl.level_we) begin
                r_level <= i_level;
            end
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.ts_nz   = r_ts_nz;
    assign o_stat.ws_nz   = r_ws_nz;
    assign o_time_sum     = r_ts;
    assign o_weighted_sum = r_ws;

endmodule

FILE: design/twba_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on twba_pkg for the default width.
module twba_div #(
    parameter int W = twba_pkg::SUM_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    import twba_pkg::*;

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_d;

    logic [W:0]    w_trial;
    logic [W+1:0]  w_diff;
    logic          w_neg;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_q[W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_d};
        w_neg   = w_diff[W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= ~i_start & r_busy & (r_cnt == CW'(W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_neg ? w_trial[W-1:0] : w_diff[W-1:0];
                r_q   <= {r_q[W-2:0], ~w_neg};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
